/* hdl/tga_rle_packet_decoder_assert.svh */
// Assertion macros for the run-length packet decoder.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef TGA_RLE_PACKET_DECODER_ASSERT_SVH
`define TGA_RLE_PACKET_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TGARLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TGARLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tgarle_pkg.sv */
// Shared types and constants of the run-length packet decoder.
// No dependencies; used by every module of the block.
package tgarle_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic [2:0]  ELEMENT_BYTES_RESET = 3'd4;
    localparam logic [29:0] PIXEL_COUNT_RESET   = 30'd1;

    typedef enum logic [0:0] {
        CFG_ELEMENT_BYTES = 1'b0,
        CFG_PIXEL_COUNT   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_RUN     = 3'b010,
        PH_LITERAL = 3'b100
    } phase_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  run_length;
        logic        frame_done;
        logic        error_flag;
    } result_t;

    typedef struct packed {
        logic push;
        logic error;
        logic halted;
    } front_status_t;

endpackage

/* hdl/tga_rle_packet_decoder.sv */
// Run-length packet decoder: one encoded byte accepted per cycle while the queue has room.
// A result word passes from the front decode into the queue, then into the output
// register.
// Each accepted byte is decoded in the front end; a four-entry queue lets the
// input keep flowing while the output is stalled, until the queue is full.
// Reset (rst_n, asynchronous, active low) halts decoding until frame_start.
module tga_rle_packet_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // Input byte channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_value,
    output logic [7:0]  run_length,
    output logic        frame_done,
    output logic        error_flag,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [29:0] cfg_data
);

    `include "tga_rle_packet_decoder_assert.svh"

    // Configuration registers. Writes are always taken; the user writes them
    // only while the decoder is idle.
    logic [2:0]  element_bytes_reg;
    logic [29:0] pixel_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_bytes_reg <= tgarle_pkg::ELEMENT_BYTES_RESET;
            pixel_count_reg   <= tgarle_pkg::PIXEL_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tgarle_pkg::cfg_index_t'(cfg_index))
                tgarle_pkg::CFG_ELEMENT_BYTES: element_bytes_reg <= cfg_data[2:0];
                tgarle_pkg::CFG_PIXEL_COUNT:   pixel_count_reg   <= cfg_data;
                default:                       pixel_count_reg   <= pixel_count_reg;
            endcase
        end
    end

    // Front end: a byte is taken whenever the queue has room, because each
    // byte produces at most one result word.
    logic                                in_accept;
    logic                                q_full;
    logic                                q_not_empty;
    logic                                q_pop;
    logic [tgarle_pkg::QUEUE_CNT_W-1:0] q_count;
    tgarle_pkg::result_t                 front_result;
    tgarle_pkg::result_t                 q_head;
    tgarle_pkg::result_t                 out_data;
    tgarle_pkg::front_status_t           front_status;

    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    tgarle_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .data_byte     (data_byte),
        .frame_start   (frame_start),
        .element_bytes (element_bytes_reg),
        .pixel_count   (pixel_count_reg),
        .result        (front_result),
        .status        (front_status)
    );

    // Queue of finished words between decode and delivery.
    tgarle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_status.push),
        .push_data (front_result),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full),
        .count     (q_count)
    );

    // Back end: output register that holds a word while the receiver stalls.
    tgarle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

    assign pixel_value = out_data.pixel_value;
    assign run_length  = out_data.run_length;
    assign frame_done  = out_data.frame_done;
    assign error_flag  = out_data.error_flag;

    // A word must never be offered to a full queue.
    `TGARLE_ASSERT_NOW(a_no_overflow, front_status.push, !q_full, "result pushed into full queue")

    // An error word always leaves the decoder halted.
    `TGARLE_ASSERT_NEXT(a_error_halts, front_status.push && front_status.error,
        front_status.halted, "decoder not halted after error")

    // Error words carry zeroed pixel fields; good words a nonzero run.
    `TGARLE_ASSERT_NOW(a_error_fields, out_valid && error_flag,
        pixel_value == 32'd0 && run_length == 8'd0 && !frame_done, "error word fields set")

    `TGARLE_ASSERT_NOW(a_run_nonzero, out_valid && !error_flag,
        run_length != 8'd0, "pixel word with zero run length")

    // The queue count never runs past its depth.
    `TGARLE_ASSERT_NOW(a_count_bound, 1'b1,
        q_count <= tgarle_pkg::QUEUE_CNT_W'(tgarle_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

/* hdl/tgarle_front.sv */
// Front end: parses headers, assembles pixel bytes and forms result words.
// Depends on tgarle_pkg.
module tgarle_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     frame_start,
    input  logic [2:0]               element_bytes,
    input  logic [29:0]              pixel_count,
    output tgarle_pkg::result_t      result,
    output tgarle_pkg::front_status_t status
);

    tgarle_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [1:0]  byte_index_reg, byte_index_next, byte_index_cur;
    logic [7:0]  packet_left_reg, packet_left_next, packet_left_cur;
    logic [31:0] acc_reg, acc_next, acc_cur, acc_merged;
    logic [29:0] owed_reg, owed_next, owed_cur;
    logic        halted_reg, halted_next, halted_cur;
    logic        produce;
    logic [7:0]  size;
    logic        bad_eb;
    logic [2:0]  eff_bytes;
    logic [2:0]  index_plus;
    logic [7:0]  left_dec;
    tgarle_pkg::result_t res;

    // A frame start reloads the budget before the byte itself is decoded.
    always_comb
    begin
        if (frame_start)
        begin
            phase_cur       = tgarle_pkg::PH_HEADER;
            byte_index_cur  = 2'd0;
            packet_left_cur = 8'd0;
            acc_cur         = 32'd0;
            owed_cur        = pixel_count;
            halted_cur      = 1'b0;
        end
        else
        begin
            phase_cur       = phase_reg;
            byte_index_cur  = byte_index_reg;
            packet_left_cur = packet_left_reg;
            acc_cur         = acc_reg;
            owed_cur        = owed_reg;
            halted_cur      = halted_reg;
        end
    end

    assign size       = {1'b0, data_byte[6:0]} + 8'd1;
    assign bad_eb     = (element_bytes == 3'd0) || (element_bytes > 3'd4);
    assign eff_bytes  = bad_eb ? 3'd4 : element_bytes;
    assign index_plus = {1'b0, byte_index_cur} + 3'd1;
    assign acc_merged = acc_cur | ({24'd0, data_byte} << {byte_index_cur, 3'b000});
    assign left_dec   = (packet_left_cur != 8'd0) ? packet_left_cur - 8'd1 : 8'd0;

    always_comb
    begin
        phase_next       = phase_cur;
        byte_index_next  = byte_index_cur;
        packet_left_next = packet_left_cur;
        acc_next         = acc_cur;
        owed_next        = owed_cur;
        halted_next      = halted_cur;
        produce          = 1'b0;
        res              = '0;
        if (!halted_cur)
        begin
            unique case (phase_cur)
                tgarle_pkg::PH_HEADER:
                begin
                    if (bad_eb || ({22'd0, size} > owed_cur))
                    begin
                        halted_next    = 1'b1;
                        produce        = 1'b1;
                        res.error_flag = 1'b1;
                    end
                    else
                    begin
                        owed_next        = owed_cur - {22'd0, size};
                        packet_left_next = size;
                        phase_next       = data_byte[7] ? tgarle_pkg::PH_RUN
                                                        : tgarle_pkg::PH_LITERAL;
                        byte_index_next  = 2'd0;
                        acc_next         = 32'd0;
                    end
                end
                tgarle_pkg::PH_RUN,
                tgarle_pkg::PH_LITERAL:
                begin
                    if (index_plus < eff_bytes)
                    begin
                        byte_index_next = index_plus[1:0];
                        acc_next        = acc_merged;
                    end
                    else
                    begin
                        produce         = 1'b1;
                        byte_index_next = 2'd0;
                        acc_next        = 32'd0;
                        res.pixel_value = acc_merged;
                        if (phase_cur == tgarle_pkg::PH_RUN)
                        begin
                            res.run_length   = packet_left_cur;
                            res.frame_done   = (owed_cur == 30'd0);
                            packet_left_next = 8'd0;
                            phase_next       = tgarle_pkg::PH_HEADER;
                        end
                        else
                        begin
                            res.run_length   = 8'd1;
                            res.frame_done   = (owed_cur == 30'd0) && (left_dec == 8'd0);
                            packet_left_next = left_dec;
                            if (left_dec == 8'd0)
                                phase_next = tgarle_pkg::PH_HEADER;
                        end
                        if (res.frame_done)
                            halted_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = tgarle_pkg::PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tgarle_pkg::PH_HEADER;
            byte_index_reg  <= 2'd0;
            packet_left_reg <= 8'd0;
            acc_reg         <= 32'd0;
            owed_reg        <= 30'd0;
            halted_reg      <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            packet_left_reg <= packet_left_next;
            acc_reg         <= acc_next;
            owed_reg        <= owed_next;
            halted_reg      <= halted_next;
        end
    end

    assign result        = res;
    assign status.push   = accept && produce;
    assign status.error  = res.error_flag;
    assign status.halted = halted_reg;

endmodule

/* hdl/tgarle_queue.sv */
// Short result queue between the front end and the output stage.
// Depends on tgarle_pkg.
module tgarle_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  tgarle_pkg::result_t                 push_data,
    input  logic                                pop,
    output tgarle_pkg::result_t                 head,
    output logic                                not_empty,
    output logic                                full,
    output logic [tgarle_pkg::QUEUE_CNT_W-1:0] count
);

    tgarle_pkg::result_t                 entry_reg [tgarle_pkg::QUEUE_DEPTH];
    logic [tgarle_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tgarle_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                               do_push, do_pop;

    assign full      = (count_reg == tgarle_pkg::QUEUE_CNT_W'(tgarle_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

/* hdl/tgarle_back.sv */
// Output stage: takes result words from the queue into the output register.
// Depends on tgarle_pkg.
module tgarle_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  tgarle_pkg::result_t q_head,
    output logic                q_pop,
    input  logic                out_stall,
    output logic                out_valid,
    output tgarle_pkg::result_t out_data
);

    logic                out_valid_reg;
    tgarle_pkg::result_t out_data_reg;
    logic                load;

    // The register refills when it is empty or its word leaves this cycle.
    assign load  = !out_valid_reg || !out_stall;
    assign q_pop = load && q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= q_not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_data_reg <= q_head;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
